// ----- rtl/command_frame_receiver_decoder_unit_assert.svh -----
// Assertion helpers shared by the frame receiver modules.
`ifndef COMMAND_FRAME_RECEIVER_DECODER_UNIT_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_DECODER_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CFRD_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CFRD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/cfrd_pkg.sv -----
`timescale 1ns / 1ps

package cfrd_pkg;

  // Default depth of the frame store.
  localparam int MAX_FRAME_DEF = 32;

  // Only the header positions of a frame are kept.
  localparam int HDR_DEPTH = 6;

  // Widest write index any legal store depth can need.
  localparam int LEN_W = 8;

  // Width of the reported frame length.
  localparam int FRAME_LEN_W = 6;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;

  // Terminator bytes.
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Count byte decoding.
  localparam logic [7:0] WIDE_FLAG   = 8'h10;
  localparam logic [3:0] COUNT_ONE   = 4'd1;
  localparam logic [3:0] COUNT_TWO   = 4'd2;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

  // What the frame store reports for the word being processed.
  typedef struct packed {
    logic             complete;
    logic [LEN_W-1:0] len;
    logic             ovf;
    hdr_t             hdr;
  } fs_result_t;

endpackage

// ----- rtl/cfrd_frame_store.sv -----
`timescale 1ns / 1ps

module cfrd_frame_store #(
  parameter int MAX_FRAME = cfrd_pkg::MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  output cfrd_pkg::fs_result_t  res
);

`include "command_frame_receiver_decoder_unit_assert.svh"

  localparam int WI_W = $clog2(MAX_FRAME + 1);

  logic                after_newline;
  logic [WI_W-1:0]     write_index;
  logic                overflow_seen;
  cfrd_pkg::hdr_t      receive_header;

  logic                after_newline_next;
  logic [WI_W-1:0]     write_index_next;
  logic                overflow_seen_next;
  cfrd_pkg::hdr_t      receive_header_next;

  logic                is_nl;
  logic                is_cr;
  logic                do_store;
  logic                room;
  logic                complete;
  logic [WI_W-1:0]     wi_stored;
  logic                ovf_stored;
  cfrd_pkg::hdr_t      hdr_stored;

  // Classify the word and apply the store, then the end-of-frame reset.
  always_comb begin
    is_nl    = (rx_byte == cfrd_pkg::CH_NL);
    is_cr    = (rx_byte == cfrd_pkg::CH_CR);
    // While armed, only terminators are kept.
    do_store = is_nl || is_cr || !after_newline;
    complete = after_newline && is_cr;
    room     = (write_index < WI_W'(MAX_FRAME));

    wi_stored  = write_index;
    ovf_stored = overflow_seen;
    hdr_stored = receive_header;
    if (do_store) begin
      if (room) begin
        wi_stored = write_index + WI_W'(1);
      end else begin
        ovf_stored = 1'b1;
      end
    end
    for (int k = 0; k < cfrd_pkg::HDR_DEPTH; k++) begin
      if (do_store && room && (write_index == WI_W'(k))) begin
        hdr_stored[k] = rx_byte;
      end
    end

    if (complete) begin
      after_newline_next  = 1'b0;
      write_index_next    = '0;
      overflow_seen_next  = 1'b0;
      receive_header_next = '0;
    end else begin
      after_newline_next  = after_newline || is_nl;
      write_index_next    = wi_stored;
      overflow_seen_next  = ovf_stored;
      receive_header_next = hdr_stored;
    end

    res.complete = complete;
    res.len      = cfrd_pkg::LEN_W'(wi_stored);
    res.ovf      = ovf_stored;
    res.hdr      = hdr_stored;
  end

  // Receive state advances once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_newline  <= 1'b0;
      write_index    <= '0;
      overflow_seen  <= 1'b0;
      receive_header <= '0;
    end else if (advance) begin
      after_newline  <= after_newline_next;
      write_index    <= write_index_next;
      overflow_seen  <= overflow_seen_next;
      receive_header <= receive_header_next;
    end
  end

  // The index stops at the store depth and overflow only occurs once it is full.
  `CFRD_ASSERT_SAME(a_wi_bound, 1'b1, write_index <= WI_W'(MAX_FRAME), "write index past depth")
  `CFRD_ASSERT_SAME(a_ovf_full, overflow_seen, write_index == WI_W'(MAX_FRAME), "overflow before full")
  `CFRD_ASSERT_NEXT(a_restart, advance && complete, (write_index == '0) && !after_newline, "no restart after frame")

endmodule

// ----- rtl/command_frame_receiver_decoder_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Data bits  Contents
// s_axis    in   8          rx_byte
// m_axis    out  64         decoded header, parameters, length, overflow
//
// Each word is registered in the input register, and a word that closes a frame
// has its result registered in the result register; a new word is taken every cycle while results drain.
// Words that do not close a frame produce no result word.
// A stalled result register holds the input register, which then holds s_tready low.
// Reset is synchronous and clears all frame and parameter state.

module command_frame_receiver_decoder_unit #(
  parameter int MAX_FRAME = cfrd_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] rx_byte
  input  logic [cfrd_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] target_device, [15:8] device_kind, [23:16] function_code,
  // [31:24] count_field, [47:32] param_one, [55:48] param_two,
  // [61:56] frame_length, [62] overflow, [63] zero
  output logic [cfrd_pkg::OUT_DATA_W-1:0] m_tdata
);

`include "command_frame_receiver_decoder_unit_assert.svh"

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 out_free;
  logic                 advance;

  cfrd_pkg::fs_result_t fs;
  cfrd_pkg::hdr_t       committed_header;
  cfrd_pkg::hdr_t       committed_header_next;
  logic [15:0]          held_param_one;
  logic [15:0]          held_param_one_next;
  logic [7:0]           held_param_two;
  logic [7:0]           held_param_two_next;
  logic [7:0]           cnt;

  // Handshake: the result register frees up when empty or being taken.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  cfrd_frame_store #(
    .MAX_FRAME(MAX_FRAME)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .res     (fs)
  );

  // Commit the stored positions and decode the parameters from them.
  always_comb begin
    committed_header_next = committed_header;
    for (int k = 0; k < cfrd_pkg::HDR_DEPTH; k++) begin
      if (cfrd_pkg::LEN_W'(k) < fs.len) begin
        committed_header_next[k] = fs.hdr[k];
      end
    end
    cnt                 = committed_header_next[3];
    held_param_one_next = held_param_one;
    held_param_two_next = held_param_two;
    if ((cnt & cfrd_pkg::WIDE_FLAG) != 8'd0) begin
      held_param_one_next = {committed_header_next[5], committed_header_next[4]};
    end else if (cnt[3:0] == cfrd_pkg::COUNT_ONE) begin
      held_param_one_next = {8'd0, committed_header_next[4]};
    end else if (cnt[3:0] == cfrd_pkg::COUNT_TWO) begin
      held_param_one_next = {8'd0, committed_header_next[4]};
      held_param_two_next = committed_header_next[5];
    end
  end

  // Frame state that survives between frames.
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_header <= '0;
      held_param_one   <= '0;
      held_param_two   <= '0;
    end else if (advance && fs.complete) begin
      committed_header <= committed_header_next;
      held_param_one   <= held_param_one_next;
      held_param_two   <= held_param_two_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && fs.complete) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fs.complete) begin
      m_tdata <= {1'b0, fs.ovf, cfrd_pkg::FRAME_LEN_W'(fs.len),
                  held_param_two_next, held_param_one_next,
                  committed_header_next[3], committed_header_next[2],
                  committed_header_next[1], committed_header_next[0]};
    end
  end

  // A word held in the input register waits; a non-terminating word leaves no result.
  `CFRD_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid, "input word lost while stalled")
  `CFRD_ASSERT_NEXT(a_no_spurious, advance && !fs.complete, !m_tvalid, "result without frame end")
  `CFRD_ASSERT_SAME(a_len_min, advance && fs.complete, fs.len != '0 || fs.ovf, "empty frame completed")

endmodule
